@@ hdl/tba_pkg.sv @@
`default_nettype none

package tba_pkg;

    localparam int OPCODE_W         = 5;
    localparam int RESULT_W         = 20;
    localparam int OPERAND_BITS_DEF = 10;

    localparam logic [OPCODE_W-1:0] OP_ADD = 5'b00010;
    localparam logic [OPCODE_W-1:0] OP_SUB = 5'b00011;
    localparam logic [OPCODE_W-1:0] OP_BGE = 5'b00100;
    localparam logic [OPCODE_W-1:0] OP_BLE = 5'b00101;
    localparam logic [OPCODE_W-1:0] OP_BEQ = 5'b00110;
    localparam logic [OPCODE_W-1:0] OP_BGT = 5'b00111;
    localparam logic [OPCODE_W-1:0] OP_BLT = 5'b01000;
    localparam logic [OPCODE_W-1:0] OP_BNE = 5'b01001;
    localparam logic [OPCODE_W-1:0] OP_MUL = 5'b01101;
    localparam logic [OPCODE_W-1:0] OP_DIV = 5'b01110;

    // Flags that travel with an item down the chain
    typedef struct packed {
        logic is_div;
        logic result_valid;
        logic divide_by_zero;
    } ctl_t;

endpackage

`default_nettype wire

@@ hdl/tba_decode.sv @@
`default_nettype none

module tba_decode
    import tba_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OPCODE_W-1:0]     operation,
    input  wire logic [OPERAND_BITS-1:0] operand_a,
    input  wire logic [OPERAND_BITS-1:0] operand_b,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output ctl_t                         out_ctl,
    output logic [RESULT_W-1:0]          out_result,
    output logic [OPERAND_BITS-1:0]      out_dvd,
    output logic [OPERAND_BITS-1:0]      out_dvs
);

    localparam int N = OPERAND_BITS;

    logic                valid_reg;
    ctl_t                ctl_reg;
    ctl_t                ctl_next;
    logic [RESULT_W-1:0] result_reg;
    logic [RESULT_W-1:0] result_next;
    logic [N-1:0]        dvd_reg;
    logic [N-1:0]        dvs_reg;

    logic [N:0]              sum;
    logic [2*N-1:0]          prod;
    logic [N-1:0]            diff;
    logic [RESULT_W+N:0]     sum_ext;
    logic [RESULT_W+2*N-1:0] prod_ext;
    logic [RESULT_W+N-1:0]   diff_ext;
    logic [RESULT_W-1:0]     one;

    assign sum      = {1'b0, operand_a} + {1'b0, operand_b};
    assign prod     = (2*N)'(operand_a) * (2*N)'(operand_b);
    assign diff     = operand_a - operand_b;
    assign sum_ext  = {{RESULT_W{1'b0}}, sum};
    assign prod_ext = {{RESULT_W{1'b0}}, prod};
    assign diff_ext = {{RESULT_W{1'b0}}, diff};
    assign one      = RESULT_W'(1);

    always_comb begin
        ctl_next    = '{is_div: 1'b0, result_valid: 1'b1, divide_by_zero: 1'b0};
        result_next = '0;
        case (operation)
            OP_ADD: result_next = sum_ext[RESULT_W-1:0];
            OP_SUB: result_next = diff_ext[RESULT_W-1:0];
            OP_BGE: result_next = (operand_a >= operand_b) ? one : '0;
            OP_BLE: result_next = (operand_a <= operand_b) ? one : '0;
            OP_BEQ: result_next = (operand_a == operand_b) ? one : '0;
            OP_BGT: result_next = (operand_a >  operand_b) ? one : '0;
            OP_BLT: result_next = (operand_a <  operand_b) ? one : '0;
            OP_BNE: result_next = (operand_a != operand_b) ? one : '0;
            OP_MUL: result_next = prod_ext[RESULT_W-1:0];
            OP_DIV: begin
                ctl_next.is_div         = 1'b1;
                ctl_next.divide_by_zero = (operand_b == '0);
            end
            default: begin
                ctl_next.result_valid = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ctl_reg    <= ctl_next;
            result_reg <= result_next;
            dvd_reg    <= operand_a;
            dvs_reg    <= operand_b;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctl    = ctl_reg;
    assign out_result = result_reg;
    assign out_dvd    = dvd_reg;
    assign out_dvs    = dvs_reg;

endmodule

`default_nettype wire

@@ hdl/tba_div_cell.sv @@
`default_nettype none

// One restoring-division step: settle one quotient bit, MSB first.
module tba_div_cell
    import tba_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire ctl_t                    in_ctl,
    input  wire logic [RESULT_W-1:0]     in_result,
    input  wire logic [OPERAND_BITS-1:0] in_rem,
    input  wire logic [OPERAND_BITS-1:0] in_dq,
    input  wire logic [OPERAND_BITS-1:0] in_dvs,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output ctl_t                         out_ctl,
    output logic [RESULT_W-1:0]          out_result,
    output logic [OPERAND_BITS-1:0]      out_rem,
    output logic [OPERAND_BITS-1:0]      out_dq,
    output logic [OPERAND_BITS-1:0]      out_dvs
);

    localparam int N = OPERAND_BITS;

    logic                valid_reg;
    ctl_t                ctl_reg;
    logic [RESULT_W-1:0] result_reg;
    logic [N-1:0]        rem_reg;
    logic [N-1:0]        rem_next;
    logic [N-1:0]        dq_reg;
    logic [N-1:0]        dq_next;
    logic [N-1:0]        dvs_reg;

    logic [N:0] part;
    logic [N:0] trial;
    logic       fits;

    // Shift in the next dividend bit and try the subtraction
    assign part     = {in_rem, in_dq[N-1]};
    assign trial    = part - {1'b0, in_dvs};
    assign fits     = !trial[N];
    assign rem_next = fits ? trial[N-1:0] : part[N-1:0];
    assign dq_next  = {in_dq[N-2:0], fits};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ctl_reg    <= in_ctl;
            result_reg <= in_result;
            rem_reg    <= rem_next;
            dq_reg     <= dq_next;
            dvs_reg    <= in_dvs;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctl    = ctl_reg;
    assign out_result = result_reg;
    assign out_rem    = rem_reg;
    assign out_dq     = dq_reg;
    assign out_dvs    = dvs_reg;

endmodule

`default_nettype wire

@@ hdl/ten_bit_alu.sv @@
`default_nettype none

// ten_bit_alu: unsigned integer ALU on two OPERAND_BITS-wide operands.
//
// Input channel (s_): one instruction per transfer; s_tdata carries the
// opcode, operand_a and operand_b. Result channel (m_): exactly one result
// transfer per instruction, in order; m_tdata carries the 20-bit result and
// m_tuser the result_valid and divide_by_zero flags.
//
// Structure: one decode cell computes add, subtract, compare and multiply,
// then a chain of OPERAND_BITS division cells each settles one quotient
// bit. Every item walks the whole chain so results leave in order.
// Throughput is one transfer per cycle while the receiver keeps m_tready
// high; every cell is a register stage with its own valid bit.
//
// When the receiver stalls, the last cell holds its result and each cell
// only advances into an empty slot, so the chain keeps accepting until
// every cell is full. Reset clears all valid bits; the chain is empty and
// ready in the first cycle after reset.
module ten_bit_alu
    import tba_pkg::*;
#(
    parameter int  OPERAND_BITS = OPERAND_BITS_DEF,
    localparam int S_TDATA_W    = ((OPCODE_W + 2 * OPERAND_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((RESULT_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // operation [4:0], operand_a, operand_b; zero fill to a whole byte
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // result [19:0]; zero fill to a whole byte
    output logic [M_TDATA_W-1:0]        m_tdata,
    // result_valid [0], divide_by_zero [1]
    output logic [1:0]                  m_tuser
);

    localparam int N = OPERAND_BITS;

    // Stage 0 is the decode cell; stages 1..N are the division cells
    logic                valid [0:N];
    logic                ready [0:N];
    ctl_t                ctl   [0:N];
    logic [RESULT_W-1:0] res   [0:N];
    logic [N-1:0]        rem   [0:N];
    logic [N-1:0]        dq    [0:N];
    logic [N-1:0]        dvs   [0:N];

    logic [RESULT_W+N-1:0] quot_ext;
    logic [RESULT_W-1:0]   result_out;

    tba_decode #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .operation  (s_tdata[OPCODE_W-1:0]),
        .operand_a  (s_tdata[OPCODE_W+N-1:OPCODE_W]),
        .operand_b  (s_tdata[OPCODE_W+2*N-1:OPCODE_W+N]),
        .out_valid  (valid[0]),
        .out_ready  (ready[0]),
        .out_ctl    (ctl[0]),
        .out_result (res[0]),
        .out_dvd    (dq[0]),
        .out_dvs    (dvs[0])
    );

    // Partial remainder starts at zero for every item
    assign rem[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        tba_div_cell #(
            .OPERAND_BITS (OPERAND_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (valid[i]),
            .in_ready   (ready[i]),
            .in_ctl     (ctl[i]),
            .in_result  (res[i]),
            .in_rem     (rem[i]),
            .in_dq      (dq[i]),
            .in_dvs     (dvs[i]),
            .out_valid  (valid[i+1]),
            .out_ready  (ready[i+1]),
            .out_ctl    (ctl[i+1]),
            .out_result (res[i+1]),
            .out_rem    (rem[i+1]),
            .out_dq     (dq[i+1]),
            .out_dvs    (dvs[i+1])
        );
    end

    assign ready[N] = m_tready;

    // Pick the quotient for a divide; a zero divisor gives zero
    assign quot_ext = {{RESULT_W{1'b0}}, dq[N]};

    always_comb begin
        result_out = res[N];
        if (ctl[N].is_div) begin
            result_out = ctl[N].divide_by_zero ? '0 : quot_ext[RESULT_W-1:0];
        end
    end

    assign m_tvalid = valid[N];
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, result_out};
    assign m_tuser  = {ctl[N].divide_by_zero, ctl[N].result_valid};

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tba_pkg::*;

    // Stream widths: opcode, operand_a and operand_b packed from bit 0 up and
    // filled to 32 bits; the 20-bit result is filled to 24 bits.
    localparam int OPND_W      = OPERAND_BITS_DEF;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 24;
    localparam int PIPE_DEPTH  = OPND_W + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 450;

    // Opcodes that give no valid result; the package only names the live ones.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LOW = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD       = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_JUMP       = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_LABEL      = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_MOV        = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_TOP = 5'd31;

    localparam logic [OPCODE_W-1:0] LIVE_OPS [10] = '{
        OP_ADD, OP_SUB, OP_BGE, OP_BLE, OP_BEQ,
        OP_BGT, OP_BLT, OP_BNE, OP_MUL, OP_DIV
    };

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic                result_valid;
        logic                divide_by_zero;
    } alu_outcome_t;

    // Holds the outcomes still owed by the ALU, oldest first, and keeps
    // a tally of what the run has exercised.
    class alu_result_board;
        alu_outcome_t owed_q[$];
        int unsigned  mismatches;
        int unsigned  instructions;
        int unsigned  results;
        int unsigned  live_results;
        int unsigned  zero_divides;

        function new();
            mismatches   = 0;
            instructions = 0;
            results      = 0;
            live_results = 0;
            zero_divides = 0;
        endfunction

        function alu_outcome_t compute_alu(logic [OPCODE_W-1:0] op,
                                           logic [OPND_W-1:0] a,
                                           logic [OPND_W-1:0] b);
            alu_outcome_t        o;
            logic [RESULT_W-1:0] wa;
            logic [RESULT_W-1:0] wb;
            wa = RESULT_W'(a);
            wb = RESULT_W'(b);
            o  = '0;
            o.result_valid = 1'b1;
            case (op)
                OP_ADD: o.value = wa + wb;
                OP_SUB: o.value = RESULT_W'(OPND_W'(a - b));
                OP_BGE: o.value = RESULT_W'(a >= b);
                OP_BLE: o.value = RESULT_W'(a <= b);
                OP_BEQ: o.value = RESULT_W'(a == b);
                OP_BGT: o.value = RESULT_W'(a > b);
                OP_BLT: o.value = RESULT_W'(a < b);
                OP_BNE: o.value = RESULT_W'(a != b);
                OP_MUL: o.value = wa * wb;
                OP_DIV: begin
                    if (b == '0) begin
                        o.divide_by_zero = 1'b1;
                    end else begin
                        o.value = wa / wb;
                    end
                end
                default: o.result_valid = 1'b0;
            endcase
            return o;
        endfunction

        function void note_instruction(logic [S_DATA_W-1:0] tdata);
            owed_q.push_back(compute_alu(tdata[OPCODE_W-1:0],
                                         tdata[OPCODE_W +: OPND_W],
                                         tdata[OPCODE_W+OPND_W +: OPND_W]));
            instructions++;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] tdata, logic [1:0] tuser);
            alu_outcome_t exp_o;
            results++;
            if (owed_q.size() == 0) begin
                $error("result transfer with nothing owed: tdata %0h tuser %0b",
                       tdata, tuser);
                mismatches++;
                return;
            end
            exp_o = owed_q.pop_front();
            if (exp_o.result_valid) live_results++;
            if (exp_o.divide_by_zero) zero_divides++;
            if (tdata[RESULT_W-1:0] !== exp_o.value) begin
                $error("result: expected %0d, got %0d", exp_o.value, tdata[RESULT_W-1:0]);
                mismatches++;
            end
            if (tdata[M_DATA_W-1:RESULT_W] !== '0) begin
                $error("tdata fill: expected 0, got %0h", tdata[M_DATA_W-1:RESULT_W]);
                mismatches++;
            end
            if (tuser[0] !== exp_o.result_valid) begin
                $error("result_valid: expected %0b, got %0b", exp_o.result_valid, tuser[0]);
                mismatches++;
            end
            if (tuser[1] !== exp_o.divide_by_zero) begin
                $error("divide_by_zero: expected %0b, got %0b",
                       exp_o.divide_by_zero, tuser[1]);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // operation [4:0], operand_a [14:5], operand_b [24:15]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // result [19:0]
    logic [1:0]          m_tuser;   // result_valid [0], divide_by_zero [1]

    alu_result_board board = new();

    // Per-cycle idling odds, in percent, for each side of the block.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycles;

    ten_bit_alu u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: end the run as failed once the cycle counter reaches its limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, board.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sample both channels at the rising edge; a transfer is noted before
    // any result in the same cycle is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_instruction(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        end
    end

    // Drop ready at random on the result side; one decision per cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one instruction, idling first at random, and hold it until the
    // block takes it. Entered and left at a falling edge.
    task automatic send_instr(input logic [OPCODE_W-1:0] op,
                              input logic [OPND_W-1:0] a,
                              input logic [OPND_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b, a, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
    endtask

    // Bias operands towards the ends of the range and towards small values.
    function automatic logic [OPND_W-1:0] pick_operand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12) return '0;
        if (roll < 24) return '1;
        if (roll < 36) return OPND_W'($urandom_range(7));
        return OPND_W'($urandom_range(1023));
    endfunction

    task automatic send_random(input int unsigned count);
        logic [OPCODE_W-1:0] op;
        logic [OPND_W-1:0]   a;
        logic [OPND_W-1:0]   b;
        for (int unsigned n = 0; n < count; n++) begin
            // Mostly live opcodes; the rest are drawn from the whole code space.
            if ($urandom_range(99) < 85) op = LIVE_OPS[$urandom_range(9)];
            else op = OPCODE_W'($urandom_range(31));
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(99) < 20) b = a;
            if (op == OP_DIV && $urandom_range(99) < 30) b = OPND_W'($urandom_range(15));
            send_instr(op, a, b);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cycles        = 0;
        send_idle_pct = 6;
        recv_idle_pct = 56;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase one: sender mostly busy, receiver stalling often.
        // Directed: carry out of add, wrap of subtract, full product, zero divisor,
        // equal operands on BGE, BLE, BEQ and BNE, dead opcodes.
        send_instr(OP_ADD, 10'd1023, 10'd1023);
        send_instr(OP_ADD, 10'd0,    10'd0);
        send_instr(OP_SUB, 10'd0,    10'd1);
        send_instr(OP_SUB, 10'd1023, 10'd0);
        send_instr(OP_MUL, 10'd1023, 10'd1023);
        send_instr(OP_MUL, 10'd0,    10'd1023);
        send_instr(OP_DIV, 10'd1023, 10'd1);
        send_instr(OP_DIV, 10'd1023, 10'd0);
        send_instr(OP_DIV, 10'd0,    10'd0);
        send_instr(OP_DIV, 10'd1000, 10'd7);
        send_instr(OP_BGE, 10'd5,    10'd5);
        send_instr(OP_BLE, 10'd5,    10'd5);
        send_instr(OP_BEQ, 10'd1023, 10'd1023);
        send_instr(OP_BGT, 10'd1023, 10'd0);
        send_instr(OP_BLT, 10'd0,    10'd1023);
        send_instr(OP_BNE, 10'd0,    10'd0);
        send_instr(OP_UNUSED_LOW, 10'd1023, 10'd1023);
        send_instr(OP_LOAD,       10'd1023, 10'd0);
        send_instr(OP_JUMP,       10'd512,  10'd1);
        send_instr(OP_LABEL,      10'd0,    10'd1023);
        send_instr(OP_MOV,        10'd341,  10'd682);
        send_instr(OP_UNUSED_TOP, 10'd1023, 10'd1023);
        send_random(RAND_PER_PHASE);
        drain_results();

        // Phase two: swap the pressure, sender idling often.
        send_idle_pct = 56;
        recv_idle_pct = 6;
        send_random(RAND_PER_PHASE);
        drain_results();

        // Phase three: back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RAND_PER_PHASE);
        drain_results();

        // Allow for stray results from a chain that should now be empty.
        repeat (4 * PIPE_DEPTH) @(negedge aclk);

        $display("Covered %0d instructions and %0d results (%0d live, %0d zero divisors)",
                 board.instructions, board.results, board.live_results,
                 board.zero_divides);
        $display("across receiver-heavy, sender-heavy and unthrottled handshakes.");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/tba_pkg.sv
hdl/tba_decode.sv
hdl/tba_div_cell.sv
hdl/ten_bit_alu.sv
dv/tb_top.sv
